// ===== design/fpc_pkg.sv =====
// Shared constants and controller/datapath interface types for the
// prefix-count tree. No dependencies.

package fpc_pkg;

   localparam int OPERATION_W        = 2;
   localparam int INDEX_W            = 11;
   localparam int SUM_W              = 16;
   localparam int LIMIT_W            = 11;
   localparam int TABLE_SIZE_DEFAULT = 1024;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

   localparam logic [OPERATION_W-1:0] OP_INC   = 2'd0;
   localparam logic [OPERATION_W-1:0] OP_DEC   = 2'd1;
   localparam logic [OPERATION_W-1:0] OP_QUERY = 2'd2;

   typedef struct packed {
      logic clear;     // zero one table entry, advance the sweep
      logic load;      // capture a new request beat
      logic walk;      // visit the next table entry
      logic rsp_load;  // move the finished sum into the response register
   } fpc_cmd_type;

   typedef struct packed {
      logic clear_last;  // sweep is on the last entry
      logic busy;        // entries still to visit or a read still in flight
   } fpc_status_type;

endpackage

// ===== design/fpc_ctrl.sv =====
// Sequencing state machine for the prefix-count tree: clearing sweep,
// request intake, tree walk and response handoff. Uses fpc_pkg.

module fpc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  fpc_pkg::fpc_status_type status,
   output fpc_pkg::fpc_cmd_type   cmd
);
   import fpc_pkg::*;

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_WALK  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_free;

   // The response register can take a new sum when it is empty or being drained.
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            cmd.walk = 1'b1;
            if (!status.busy && rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== design/fpc_datapath.sv =====
// Datapath of the prefix-count tree: count memory, walk position,
// accumulator, limit register and response register. Uses fpc_pkg.

module fpc_datapath #(
   parameter int TABLE_SIZE = fpc_pkg::TABLE_SIZE_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [fpc_pkg::OPERATION_W-1:0]    req_operation,
   input  logic [fpc_pkg::INDEX_W-1:0]        req_index,
   input  logic                               csr_wr_en,
   input  logic [fpc_pkg::LIMIT_W-1:0]        csr_size_in_use,
   output logic signed [fpc_pkg::SUM_W-1:0]   rsp_prefix_sum,
   input  fpc_pkg::fpc_cmd_type               cmd,
   output fpc_pkg::fpc_status_type            status
);
   import fpc_pkg::*;

   localparam int ADDR_W = $clog2(TABLE_SIZE);
   // Wide enough for the table size, one climb step past it, and any request index.
   localparam int POS_W  = ($clog2(TABLE_SIZE) + 2 > INDEX_W) ? $clog2(TABLE_SIZE) + 2
                                                              : INDEX_W + 1;
   localparam logic [POS_W-1:0]  TABLE_POS = POS_W'(TABLE_SIZE);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_SIZE - 1);

   logic [SUM_W-1:0] mem [TABLE_SIZE];

   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               live_ff, live_in;
   logic               pending_ff, pending_in;
   logic               query_ff, query_in;
   logic               dec_ff, dec_in;
   logic [ADDR_W-1:0]  wr_addr_ff, wr_addr_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic [SUM_W-1:0]   acc_ff, acc_in;
   logic [SUM_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [SUM_W-1:0]   rd_data_ff;

   logic [POS_W-1:0]   limit_eff;
   logic [POS_W-1:0]   index_ext;
   logic [POS_W-1:0]   query_start;
   logic               update_ok;
   logic [POS_W-1:0]   lowbit;
   logic [POS_W-1:0]   pos_next;
   logic [ADDR_W-1:0]  rd_addr;
   logic               mem_wr_en;
   logic [ADDR_W-1:0]  mem_wr_addr;
   logic [SUM_W-1:0]   mem_wr_data;
   logic [SUM_W-1:0]   delta;

   assign limit_eff   = (POS_W'(limit_ff) > TABLE_POS) ? TABLE_POS : POS_W'(limit_ff);
   assign index_ext   = POS_W'(req_index);
   assign query_start = (index_ext > TABLE_POS) ? TABLE_POS : index_ext;
   assign update_ok   = (index_ext != '0) && (index_ext <= limit_eff);

   // Updates climb by the lowest set bit, queries strip it.
   assign lowbit   = pos_ff & (~pos_ff + POS_W'(1));
   assign pos_next = query_ff ? (pos_ff - lowbit) : (pos_ff + lowbit);
   assign rd_addr  = ADDR_W'(pos_ff - POS_W'(1));

   assign delta       = dec_ff ? {SUM_W{1'b1}} : SUM_W'(1);
   assign mem_wr_en   = cmd.clear || (pending_ff && !query_ff);
   assign mem_wr_addr = cmd.clear ? clr_addr_ff : wr_addr_ff;
   assign mem_wr_data = cmd.clear ? '0 : (rd_data_ff + delta);

   always_comb begin
      limit_in    = csr_wr_en ? csr_size_in_use : limit_ff;
      pos_in      = pos_ff;
      live_in     = live_ff;
      query_in    = query_ff;
      dec_in      = dec_ff;
      wr_addr_in  = wr_addr_ff;
      pending_in  = cmd.walk && live_ff;
      clr_addr_in = cmd.clear ? (clr_addr_ff + ADDR_W'(1)) : clr_addr_ff;
      acc_in      = acc_ff;
      rsp_data_in = cmd.rsp_load ? acc_ff : rsp_data_ff;

      if (cmd.load) begin
         query_in = (req_operation == OP_QUERY);
         dec_in   = (req_operation == OP_DEC);
         acc_in   = '0;
         unique case (req_operation)
            OP_INC, OP_DEC: begin
               pos_in  = index_ext;
               live_in = update_ok;
            end
            OP_QUERY: begin
               pos_in  = query_start;
               live_in = (query_start != '0);
            end
            default: begin
               pos_in  = index_ext;
               live_in = 1'b0;
            end
         endcase
      end else begin
         if (cmd.walk && live_ff) begin
            // Issue the read of this entry; its write-back lands next cycle.
            wr_addr_in = rd_addr;
            pos_in     = pos_next;
            live_in    = query_ff ? (pos_next != '0) : (pos_next <= limit_eff);
         end
         if (pending_ff && query_ff) begin
            acc_in = acc_ff + rd_data_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= LIMIT_RESET;
         live_ff     <= 1'b0;
         pending_ff  <= 1'b0;
         clr_addr_ff <= '0;
      end else begin
         limit_ff    <= limit_in;
         live_ff     <= live_in;
         pending_ff  <= pending_in;
         clr_addr_ff <= clr_addr_in;
      end
      pos_ff      <= pos_in;
      query_ff    <= query_in;
      dec_ff      <= dec_in;
      wr_addr_ff  <= wr_addr_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.clear_last = (clr_addr_ff == LAST_ADDR);
   assign status.busy       = live_ff || pending_ff;
   assign rsp_prefix_sum    = rsp_data_ff;

endmodule

// ===== design/fenwick_prefix_count.sv =====
// Binary indexed tree of 16-bit counts: increment, decrement and prefix-sum
// query. Uses fpc_pkg, fpc_ctrl and fpc_datapath.
//
// Request channel (req_valid/req_stall, req_operation, req_index): operation
// 0 adds one at the index, 1 subtracts one, 2 asks for the sum of positions
// 1..index. Every request beat yields exactly one response beat on
// rsp_valid/rsp_stall carrying rsp_prefix_sum (zero for updates and for code 3).
// csr_wr_en/csr_size_in_use set the highest position updates climb to; write
// it only while no request is in progress.
// One request is worked on at a time: the next one is taken only after the
// previous sum has moved into the response register. An item visits at most
// log2(TABLE_SIZE)+1 table entries, 11 for a 1024-entry table. The walk reads
// one entry per cycle from a single memory read port; updates write back
// through the write port in the cycle after each read.
// After reset the block clears every table entry, one entry per cycle, with
// req_stall high; the limit returns to 1024.
// A finished sum waits in the response register while rsp_stall is high;
// the block still accepts the next request and only holds its own result
// until that register is free.

module fenwick_prefix_count #(
   parameter int TABLE_SIZE = fpc_pkg::TABLE_SIZE_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [fpc_pkg::OPERATION_W-1:0]    req_operation,
   input  logic [fpc_pkg::INDEX_W-1:0]        req_index,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [fpc_pkg::SUM_W-1:0]   rsp_prefix_sum,
   input  logic                               csr_wr_en,
   input  logic [fpc_pkg::LIMIT_W-1:0]        csr_size_in_use
);
   import fpc_pkg::*;

   fpc_cmd_type    cmd;
   fpc_status_type status;

   fpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fpc_datapath #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_operation   (req_operation),
      .req_index       (req_index),
      .csr_wr_en       (csr_wr_en),
      .csr_size_in_use (csr_size_in_use),
      .rsp_prefix_sum  (rsp_prefix_sum),
      .cmd             (cmd),
      .status          (status)
   );

`ifndef NO_ASSERTIONS
   // A new request must never arrive while the previous walk is still running.
   a_accept_not_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !status.busy)
      else $error("request accepted during a walk");

   // The clearing sweep owns the memory exclusively.
   a_clear_exclusive: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> (!cmd.load && !cmd.walk && !cmd.rsp_load))
      else $error("clearing sweep overlaps other work");

   // A sum is handed over only once the walk has drained.
   a_rsp_after_walk: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !status.busy)
      else $error("response loaded before the walk finished");

   // A beat in the response register is never replaced before it is taken.
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !cmd.rsp_load)
      else $error("stalled response overwritten");
`endif

endmodule

// ===== test/fpc_checker.sv =====
// Scoreboard for the prefix-count tree: watches the request, response and CSR
// ports, keeps its own copy of the count tree, and compares every response beat.
// Depends on fpc_pkg.

module fpc_checker #(
   parameter int TABLE_SIZE = fpc_pkg::TABLE_SIZE_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [fpc_pkg::OPERATION_W-1:0]    req_operation,
   input  logic [fpc_pkg::INDEX_W-1:0]        req_index,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic signed [fpc_pkg::SUM_W-1:0]   rsp_prefix_sum,
   input  logic                               csr_wr_en,
   input  logic [fpc_pkg::LIMIT_W-1:0]        csr_size_in_use,
   output int                                 fail_count,
   output int                                 pending,
   output int                                 beats_checked
);

   timeunit 1ns;
   timeprecision 1ps;

   import fpc_pkg::*;

   logic [SUM_W-1:0]          count_tree [TABLE_SIZE];
   logic [LIMIT_W-1:0]        climb_limit;
   logic signed [SUM_W-1:0]   expected_sums [$];
   int                        errors = 0;
   int                        checked = 0;

   // Applies one request to the tree copy and returns the sum the block owes.
   function automatic logic signed [SUM_W-1:0] tree_step(input logic [OPERATION_W-1:0] op,
                                                         input logic [INDEX_W-1:0] idx);
      int               pos;
      int               lim;
      logic [SUM_W-1:0] delta;
      logic [SUM_W-1:0] total;
      pos   = int'(idx);
      lim   = (int'(climb_limit) < TABLE_SIZE) ? int'(climb_limit) : TABLE_SIZE;
      total = '0;
      case (op)
         OP_INC, OP_DEC: begin
            delta = (op == OP_INC) ? SUM_W'(1) : {SUM_W{1'b1}};
            // Position zero never advances, so it is skipped outright.
            if (pos != 0) begin
               while (pos <= lim) begin
                  count_tree[pos-1] = count_tree[pos-1] + delta;
                  pos = pos + (pos & -pos);
               end
            end
         end
         OP_QUERY: begin
            if (pos > TABLE_SIZE) pos = TABLE_SIZE;
            while (pos != 0) begin
               total = total + count_tree[pos-1];
               pos = pos - (pos & -pos);
            end
         end
         default: ;
      endcase
      return total;
   endfunction

   always @(posedge clock) begin
      logic signed [SUM_W-1:0] want;
      if (reset) begin
         for (int i = 0; i < TABLE_SIZE; i++) count_tree[i] = '0;
         climb_limit = LIMIT_RESET;
         expected_sums.delete();
      end else begin
         if (csr_wr_en) climb_limit = csr_size_in_use;
         if (rsp_valid && !rsp_stall) begin
            if (expected_sums.size() == 0) begin
               errors++;
               $display("%0t: response beat with nothing expected, actual %0d",
                        $time, rsp_prefix_sum);
            end else begin
               want = expected_sums.pop_front();
               checked++;
               if (rsp_prefix_sum !== want) begin
                  errors++;
                  $display("%0t: prefix_sum mismatch, expected %0d actual %0d",
                           $time, want, rsp_prefix_sum);
               end
            end
         end
         if (req_valid && !req_stall)
            expected_sums.push_back(tree_step(req_operation, req_index));
      end
      fail_count    <= errors;
      pending       <= expected_sums.size();
      beats_checked <= checked;
   end

endmodule

// ===== test/tb_fenwick_prefix_count.sv =====
// Top of the prefix-count tree testbench: clock, reset, request and CSR
// stimulus, response back-pressure and the verdict.
// Depends on fpc_pkg, fenwick_prefix_count and fpc_checker.

module tb_fenwick_prefix_count;

   timeunit 1ns;
   timeprecision 1ps;

   import fpc_pkg::*;

   localparam logic [OPERATION_W-1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int PHASE_ITEMS  = 194;
   localparam int DRAIN_CYCLES = 40;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [OPERATION_W-1:0]   req_operation;
   logic [INDEX_W-1:0]       req_index;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic signed [SUM_W-1:0]  rsp_prefix_sum;
   logic                     csr_wr_en;
   logic [LIMIT_W-1:0]       csr_size_in_use;

   int fail_count;
   int pending;
   int beats_checked;
   int cycles = 0;
   int beats_sent = 0;
   int settings_used = 1;
   int rsp_hold;
   int current_limit = 1024;
   bit req_quiet = 1'b0;
   bit rsp_quiet = 1'b0;

   fenwick_prefix_count dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_index       (req_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_prefix_sum  (rsp_prefix_sum),
      .csr_wr_en       (csr_wr_en),
      .csr_size_in_use (csr_size_in_use)
   );

   fpc_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_index       (req_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_prefix_sum  (rsp_prefix_sum),
      .csr_wr_en       (csr_wr_en),
      .csr_size_in_use (csr_size_in_use),
      .fail_count      (fail_count),
      .pending         (pending),
      .beats_checked   (beats_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding", cycles, pending);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Response side: after each accepted beat, stall for a drawn number of cycles.
   always @(posedge clock) begin
      int n;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold  <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         n = rsp_quiet ? 0 : $urandom_range(0, 6);
         rsp_stall <= (n != 0);
         rsp_hold  <= (n == 0) ? 0 : n - 1;
      end else if (rsp_hold != 0) begin
         rsp_stall <= 1'b1;
         rsp_hold  <= rsp_hold - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_item(input logic [OPERATION_W-1:0] op, input logic [INDEX_W-1:0] idx);
      int gap;
      gap = req_quiet ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_index     <= idx;
      do @(posedge clock); while (req_stall);
      beats_sent++;
   endtask

   // Holds the request side until every owed response has been taken.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic set_limit(input int value);
      wait_idle();
      csr_wr_en       <= 1'b1;
      csr_size_in_use <= LIMIT_W'(value);
      @(posedge clock);
      csr_wr_en       <= 1'b0;
      current_limit = value;
      settings_used++;
   endtask

   function automatic logic [INDEX_W-1:0] pick_index();
      int sel;
      int lim;
      sel = $urandom_range(0, 9);
      lim = (current_limit < 1024) ? current_limit : 1024;
      if (sel < 6) return INDEX_W'($urandom_range(0, (lim == 0) ? 4 : lim));
      else if (sel < 8) return INDEX_W'($urandom_range(1, 1024));
      else if (sel == 8) return INDEX_W'($urandom_range(1025, 2047));
      else return INDEX_W'($urandom_range(0, 16));
   endfunction

   function automatic logic [OPERATION_W-1:0] pick_operation();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return OP_INC;
      else if (r < 60) return OP_DEC;
      else if (r < 96) return OP_QUERY;
      else return OP_UNUSED;
   endfunction

   initial begin
      int limits [8];
      limits = '{1024, 1023, 2047, 1, 0, 2, 512, 0};
      limits[7] = $urandom_range(3, 1024);

      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_operation   <= OP_INC;
      req_index       <= '0;
      csr_wr_en       <= 1'b0;
      csr_size_in_use <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset limit: edges of the index range and every code.
      send_item(OP_INC, 11'd1);
      send_item(OP_INC, 11'd2);
      send_item(OP_INC, 11'd1023);
      send_item(OP_INC, 11'd1024);
      send_item(OP_INC, 11'd0);
      send_item(OP_INC, 11'd2047);
      send_item(OP_DEC, 11'd3);
      send_item(OP_DEC, 11'd3);
      send_item(OP_QUERY, 11'd0);
      send_item(OP_QUERY, 11'd1);
      send_item(OP_QUERY, 11'd3);
      send_item(OP_QUERY, 11'd1023);
      send_item(OP_QUERY, 11'd1024);
      send_item(OP_QUERY, 11'd1500);
      send_item(OP_QUERY, 11'd2047);
      send_item(OP_UNUSED, 11'd5);
      send_item(OP_QUERY, 11'd5);

      // With the limit at zero no update lands anywhere.
      set_limit(0);
      send_item(OP_INC, 11'd5);
      send_item(OP_QUERY, 11'd5);

      // A limit past the table behaves as the full table.
      set_limit(2047);
      send_item(OP_DEC, 11'd1024);
      send_item(OP_QUERY, 11'd1024);

      // With a limit of one, only position one is ever updated.
      set_limit(1);
      send_item(OP_INC, 11'd1);
      send_item(OP_INC, 11'd2);
      send_item(OP_QUERY, 11'd2);

      for (int p = 0; p < 8; p++) begin
         set_limit(limits[p]);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (k % 32 == 0) begin
               req_quiet = ($urandom_range(0, 3) == 0);
               rsp_quiet = ($urandom_range(0, 3) == 0);
            end
            send_item(pick_operation(), pick_index());
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d request beats across %0d limit settings; %0d responses compared.",
               beats_sent, settings_used, beats_checked);
      if (fail_count == 0 && pending == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== sim.f =====
design/fpc_pkg.sv
design/fpc_ctrl.sv
design/fpc_datapath.sv
design/fenwick_prefix_count.sv
test/fpc_checker.sv
test/tb_fenwick_prefix_count.sv
